// ===== design/lcra_pkg.sv =====
// Shared types and constants of the least-recently-granted request arbiter.
`default_nettype none
package lcra_pkg;

    localparam int ID_W   = 4;
    localparam int PEND_W = 8;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    typedef struct packed {
        logic            opcode;
        logic [ID_W-1:0] requester_id;
    } in_item_t;

    typedef struct packed {
        logic              grant_valid;
        logic [ID_W-1:0]   granted_id;
        logic [PEND_W-1:0] still_pending;
    } out_item_t;

    typedef struct packed {
        logic start;       // take the item, clear results, issue first reads
        logic scan_step;   // move to next service-order entry
        logic grant;       // latch granted requester, read its count
        logic dec;         // write back decremented count
        logic shift_step;  // pull one entry forward
        logic tail_write;  // put granted requester at the tail
        logic push_upd;    // apply a push
        logic load_out;    // move result into output register
    } dp_cmd_t;

    typedef struct packed {
        logic in_is_pop;
        logic in_id_ok;
        logic list_empty;
        logic cand_pending;
        logic more_after1;
        logic more_after2;
    } dp_status_t;

endpackage
`default_nettype wire

// ===== design/lcra_ctrl.sv =====
// Sequencer of the arbiter: walks push and pop operations through the datapath.
`default_nettype none
module lcra_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    output logic                    m_valid,
    input  wire logic               m_ready,
    input  wire lcra_pkg::dp_status_t status,
    output lcra_pkg::dp_cmd_t       cmd
);
    import lcra_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_SCAN  = 7'b0000010,
        ST_DEC   = 7'b0000100,
        ST_SHIFT = 7'b0001000,
        ST_TAIL  = 7'b0010000,
        ST_PUSH  = 7'b0100000,
        ST_RESP  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.start = 1'b1;
                    priority if (status.in_is_pop && status.list_empty) begin
                        state_next = ST_RESP;
                    end else if (status.in_is_pop) begin
                        state_next = ST_SCAN;
                    end else if (!status.in_id_ok) begin
                        state_next = ST_RESP;
                    end else begin
                        state_next = ST_PUSH;
                    end
                end
            end
            ST_SCAN: begin
                priority if (status.cand_pending) begin
                    cmd.grant  = 1'b1;
                    state_next = ST_DEC;
                end else if (!status.more_after1) begin
                    state_next = ST_RESP;   // nothing pending anywhere
                end else begin
                    cmd.scan_step = 1'b1;
                end
            end
            ST_DEC: begin
                cmd.dec    = 1'b1;
                state_next = status.more_after1 ? ST_SHIFT : ST_RESP;
            end
            ST_SHIFT: begin
                cmd.shift_step = 1'b1;
                if (!status.more_after2) begin
                    state_next = ST_TAIL;
                end
            end
            ST_TAIL: begin
                cmd.tail_write = 1'b1;
                state_next     = ST_RESP;
            end
            ST_PUSH: begin
                cmd.push_upd = 1'b1;
                state_next   = ST_RESP;
            end
            ST_RESP: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule
`default_nettype wire

// ===== design/lcra_dp.sv =====
// Datapath of the arbiter: service-order and count memories, flags and result registers.
`default_nettype none
module lcra_dp #(
    parameter int REQUESTERS = 16,
    parameter int COUNT_BITS = 8
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire lcra_pkg::in_item_t  s_data,
    input  wire lcra_pkg::dp_cmd_t   cmd,
    output lcra_pkg::dp_status_t     status,
    output lcra_pkg::out_item_t      m_data
);
    import lcra_pkg::*;

    localparam int IDX_W = $clog2(REQUESTERS);
    localparam int CNT_W = $clog2(REQUESTERS + 1);
    localparam int CMP_W = CNT_W + 1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // memories
    logic [ID_W-1:0]       order_mem [REQUESTERS];
    logic [COUNT_BITS-1:0] count_mem [REQUESTERS];

    logic [ID_W-1:0]       order_rd_reg;
    logic [COUNT_BITS-1:0] count_rd_reg;

    logic [IDX_W-1:0]      pos_reg, pos_next;
    logic [CNT_W-1:0]      total_reg, total_next;
    logic [ID_W-1:0]       id_reg;
    logic [ID_W-1:0]       who_reg;
    logic [REQUESTERS-1:0] seen_reg, seen_next;
    logic [REQUESTERS-1:0] nz_reg, nz_next;
    out_item_t             res_reg;
    out_item_t             m_data_reg;

    logic [IDX_W-1:0]      in_idx, ord_idx, id_idx, who_idx;
    logic [CMP_W-1:0]      pos_ext, tot_ext;
    logic                  room;
    logic [COUNT_BITS-1:0] count_dec;

    logic                  ord_we;
    logic [IDX_W-1:0]      ord_wa, ord_ra;
    logic [ID_W-1:0]       ord_wd;
    logic                  cnt_we;
    logic [IDX_W-1:0]      cnt_wa, cnt_ra;
    logic [COUNT_BITS-1:0] cnt_wd;

    assign in_idx    = IDX_W'(s_data.requester_id);
    assign ord_idx   = IDX_W'(order_rd_reg);
    assign id_idx    = IDX_W'(id_reg);
    assign who_idx   = IDX_W'(who_reg);
    assign pos_ext   = CMP_W'(pos_reg);
    assign tot_ext   = CMP_W'(total_reg);
    assign room      = tot_ext < CMP_W'(REQUESTERS);
    assign count_dec = count_rd_reg - COUNT_BITS'(1);

    assign status.in_is_pop    = (s_data.opcode == OP_POP);
    assign status.in_id_ok     = (32'(s_data.requester_id) < REQUESTERS);
    assign status.list_empty   = (total_reg == '0);
    assign status.cand_pending = nz_reg[ord_idx];
    assign status.more_after1  = (pos_ext + CMP_W'(1)) < tot_ext;
    assign status.more_after2  = (pos_ext + CMP_W'(2)) < tot_ext;

    assign m_data = m_data_reg;

    // memory port selection
    always_comb begin
        ord_we = 1'b0;
        ord_wa = pos_reg;
        ord_wd = order_rd_reg;
        if (cmd.shift_step) begin
            ord_we = 1'b1;
        end else if (cmd.tail_write) begin
            ord_we = 1'b1;
            ord_wd = who_reg;
        end else if (cmd.push_upd && !seen_reg[id_idx] && room) begin
            ord_we = 1'b1;
            ord_wa = total_reg[IDX_W-1:0];
            ord_wd = id_reg;
        end

        priority if (cmd.start) begin
            ord_ra = '0;
        end else if (cmd.shift_step) begin
            ord_ra = pos_reg + IDX_W'(2);
        end else begin
            ord_ra = pos_reg + IDX_W'(1);
        end

        cnt_we = 1'b0;
        cnt_wa = id_idx;
        cnt_wd = count_dec;
        if (cmd.dec) begin
            cnt_we = 1'b1;
            cnt_wa = who_idx;
        end else if (cmd.push_upd) begin
            if (!seen_reg[id_idx]) begin
                cnt_we = 1'b1;
                cnt_wd = COUNT_BITS'(1);
            end else if (count_rd_reg != COUNT_MAX) begin
                cnt_we = 1'b1;
                cnt_wd = count_rd_reg + COUNT_BITS'(1);
            end
        end
        cnt_ra = cmd.start ? in_idx : ord_idx;
    end

    always_ff @(posedge aclk) begin
        if (ord_we) begin
            order_mem[ord_wa] <= ord_wd;
        end
        order_rd_reg <= order_mem[ord_ra];
    end

    always_ff @(posedge aclk) begin
        if (cnt_we) begin
            count_mem[cnt_wa] <= cnt_wd;
        end
        count_rd_reg <= count_mem[cnt_ra];
    end

    // control-side state
    always_comb begin
        pos_next   = pos_reg;
        total_next = total_reg;
        seen_next  = seen_reg;
        nz_next    = nz_reg;
        if (cmd.start) begin
            pos_next = '0;
        end
        if (cmd.scan_step || cmd.shift_step) begin
            pos_next = pos_reg + IDX_W'(1);
        end
        if (cmd.push_upd) begin
            seen_next[id_idx] = 1'b1;
            nz_next[id_idx]   = 1'b1;
            if (!seen_reg[id_idx] && room) begin
                total_next = total_reg + CNT_W'(1);
            end
        end
        if (cmd.dec) begin
            nz_next[who_idx] = (count_dec != '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            total_reg <= '0;
            seen_reg  <= '0;
            nz_reg    <= '0;
        end else begin
            pos_reg   <= pos_next;
            total_reg <= total_next;
            seen_reg  <= seen_next;
            nz_reg    <= nz_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            id_reg  <= s_data.requester_id;
            res_reg <= '0;
        end
        if (cmd.grant) begin
            who_reg              <= order_rd_reg;
            res_reg.grant_valid  <= 1'b1;
            res_reg.granted_id   <= order_rd_reg;
        end
        if (cmd.dec) begin
            res_reg.still_pending <= PEND_W'(count_dec);
        end
        if (cmd.load_out) begin
            m_data_reg <= res_reg;
        end
    end

endmodule
`default_nettype wire

// ===== design/lru_counted_request_arbiter_top.sv =====
// Top level of the least-recently-granted request arbiter with pending counts.
`default_nettype none
// Takes one item at a time: a push adds a pending request for a requester, a pop
// grants the first requester with a pending request in least-recently-granted order
// and moves it to the tail. Every item returns exactly one result through an output
// register; a push result is all zero. A push with a valid id goes through an update
// state to the response state. A granting pop walks the service order to the first
// requester with a pending request, decrements its count, shifts the entries after it
// forward and writes it at the tail. The walk that finds it and the shift that moves it to
// the tail each go one entry per cycle through the single read port of the
// service-order memory, and together they pass over the n entries once, where n is
// the number of distinct requesters seen. A pop with nothing pending walks all n
// entries, or goes straight to the response state when no requester has been seen.
// A result waits in the response state until the output register is free. The
// next item can be accepted at the edge after the previous result reaches the output
// register.
module lru_counted_request_arbiter_top #(
    parameter int REQUESTERS = 16,
    parameter int COUNT_BITS = 8
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire lcra_pkg::in_item_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output lcra_pkg::out_item_t      m_data
);
    import lcra_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    lcra_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    lcra_dp #(
        .REQUESTERS (REQUESTERS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .status  (status),
        .m_data  (m_data)
    );

endmodule
`default_nettype wire

// ===== design/lcra_checker.sv =====
// Port-level checks of the arbiter and their binding to the top level.
`default_nettype none
module lcra_checker (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_valid,
    input wire logic                s_ready,
    input wire lcra_pkg::in_item_t  s_data,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire lcra_pkg::out_item_t m_data
);
    import lcra_pkg::*;

    // a stalled result stays put
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // one item at a time: ready drops right after an accept
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("item accepted while another is in flight");

    // a result without a grant carries no id and no count
    a_no_grant_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.grant_valid |->
            m_data.granted_id == '0 && m_data.still_pending == '0)
        else $error("non-grant result with nonzero fields");

    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("block not idle after reset");

endmodule

bind lru_counted_request_arbiter_top lcra_checker u_lcra_checker (.*);
`default_nettype wire

// ===== test/tb_lru_counted_request_arbiter_top.sv =====
// Testbench for the least-recently-granted request arbiter: directed and random items.
`default_nettype none
module tb_lru_counted_request_arbiter_top;
    timeunit 1ns;
    timeprecision 1ps;
    import lcra_pkg::*;

    localparam int NUM_REQ    = 16;
    localparam int COUNT_TOP  = 255;
    localparam int CYCLE_CAP  = 600000;
    localparam int RAND_ITEMS = 1230;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    lru_counted_request_arbiter_top #(
        .REQUESTERS(NUM_REQ),
        .COUNT_BITS(8)
    ) dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // predictor state
    logic [7:0] req_count [NUM_REQ];
    logic       req_known [NUM_REQ];
    logic [3:0] lru_order [NUM_REQ];
    int         known_total;

    in_item_t  req_backlog[$];
    out_item_t grant_expect[$];
    int        mismatches;
    int        item_total;
    int        cycle_count;
    int        send_gap;
    int        recv_stall;
    int        calm_left;
    logic      tail_quiet;

    function automatic out_item_t grant_for(in_item_t it);
        out_item_t  res;
        int         hit;
        logic [3:0] who;
        res = '0;
        hit = -1;
        if (it.opcode == OP_PUSH) begin
            if (!req_known[it.requester_id]) begin
                lru_order[known_total] = it.requester_id;
                known_total++;
                req_known[it.requester_id] = 1'b1;
                req_count[it.requester_id] = 8'd1;
            end else if (req_count[it.requester_id] != COUNT_TOP) begin
                req_count[it.requester_id]++;
            end
            return res;
        end
        for (int i = 0; i < known_total; i++) begin
            if (hit < 0 && req_count[lru_order[i]] != 0)
                hit = i;
        end
        if (hit < 0)
            return res;
        who = lru_order[hit];
        req_count[who]--;
        // rotate the granted requester to the tail
        for (int i = hit; i < known_total - 1; i++)
            lru_order[i] = lru_order[i + 1];
        lru_order[known_total - 1] = who;
        res.grant_valid   = 1'b1;
        res.granted_id    = who;
        res.still_pending = req_count[who];
        return res;
    endfunction

    task automatic add_item(logic op, logic [3:0] id);
        in_item_t it;
        it.opcode       = op;
        it.requester_id = id;
        req_backlog.push_back(it);
        item_total++;
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                grant_expect.push_back(grant_for(s_data));
                if (calm_left > 0)
                    calm_left <= calm_left - 1;
                else if ($urandom_range(0, 39) == 0)
                    calm_left <= $urandom_range(20, 80);
            end
            tail_quiet <= (req_backlog.size() < 100);
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_valid  <= 1'b0;
                end else if (!tail_quiet && calm_left == 0 && $urandom_range(0, 5) == 0) begin
                    send_gap <= $urandom_range(0, 17);
                    s_valid  <= 1'b0;
                end else if (req_backlog.size() > 0) begin
                    s_valid <= 1'b1;
                    s_data  <= req_backlog.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and result stalls
    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (grant_expect.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: got %0b/%0d/%0d",
                                 m_data.grant_valid, m_data.granted_id, m_data.still_pending);
                end else begin
                    want = grant_expect.pop_front();
                    if (m_data.grant_valid !== want.grant_valid
                        || m_data.granted_id !== want.granted_id
                        || m_data.still_pending !== want.still_pending) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp valid %0b id %0d pend %0d, got valid %0b id %0d pend %0d",
                                     want.grant_valid, want.granted_id, want.still_pending,
                                     m_data.grant_valid, m_data.granted_id, m_data.still_pending);
                    end
                end
            end
            if (recv_stall > 0) begin
                recv_stall <= recv_stall - 1;
                m_ready    <= 1'b0;
            end else if (!tail_quiet && calm_left == 0 && $urandom_range(0, 7) == 0) begin
                recv_stall <= $urandom_range(0, 17);
                m_ready    <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("FAIL lru_counted_request_arbiter_top");
            $finish;
        end
    end

    initial begin
        int         kind;
        int         len;
        logic [3:0] sat_id;
        mismatches  = 0;
        item_total  = 0;
        cycle_count = 0;
        send_gap    = 0;
        recv_stall  = 0;
        calm_left   = 0;
        tail_quiet  = 1'b0;
        known_total = 0;
        for (int i = 0; i < NUM_REQ; i++) begin
            req_count[i] = '0;
            req_known[i] = 1'b0;
            lru_order[i] = '0;
        end

        // directed: empty pop, extreme ids, repeat pushes, rotation, repeat push at zero count
        add_item(OP_POP, 4'd9);
        add_item(OP_PUSH, 4'd0);
        add_item(OP_PUSH, 4'd15);
        add_item(OP_PUSH, 4'd0);
        add_item(OP_PUSH, 4'd5);
        add_item(OP_PUSH, 4'd10);
        add_item(OP_POP, 4'd15);
        add_item(OP_POP, 4'd0);
        add_item(OP_POP, 4'd3);
        add_item(OP_POP, 4'd12);
        add_item(OP_POP, 4'd7);
        add_item(OP_POP, 4'd0);
        add_item(OP_PUSH, 4'd15);
        add_item(OP_PUSH, 4'd3);
        add_item(OP_PUSH, 4'd0);
        add_item(OP_POP, 4'd15);
        add_item(OP_POP, 4'd15);
        add_item(OP_POP, 4'd15);
        add_item(OP_PUSH, 4'd7);
        add_item(OP_PUSH, 4'd7);
        add_item(OP_POP, 4'd1);
        add_item(OP_POP, 4'd1);

        // saturate one requester so the upper count bits and the ceiling are exercised
        sat_id = 4'($urandom_range(0, 15));
        for (int i = 0; i < 262; i++)
            add_item(OP_PUSH, sat_id);
        for (int i = 0; i < 3; i++)
            add_item(OP_POP, 4'($urandom));

        while (item_total < RAND_ITEMS) begin
            kind = $urandom_range(0, 9);
            len  = $urandom_range(1, 6);
            for (int i = 0; i < len; i++) begin
                if (kind < 4)
                    add_item(OP_PUSH, 4'($urandom));
                else if (kind < 7)
                    add_item(OP_POP, 4'($urandom));
                else
                    add_item(1'($urandom), 4'($urandom));
            end
        end

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        while (req_backlog.size() != 0 || s_valid || grant_expect.size() != 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (mismatches == 0 && grant_expect.size() == 0)
            $display("PASS lru_counted_request_arbiter_top");
        else
            $display("FAIL lru_counted_request_arbiter_top");
        $finish;
    end

endmodule
`default_nettype wire

// ===== lru_counted_request_arbiter_top.f =====
design/lcra_pkg.sv
design/lcra_ctrl.sv
design/lcra_dp.sv
design/lru_counted_request_arbiter_top.sv
design/lcra_checker.sv
test/tb_lru_counted_request_arbiter_top.sv
